[src/psnr_pkg.sv]
// psnr_pkg: shared widths, register indexes, queue entry type and the
// squared-difference helper for the PSNR error accumulator.
// No dependencies.
package psnr_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int DIM_CFG_W   = 13;
  localparam int BORDER_W    = 11;
  localparam int ACC_W       = 42;
  localparam int PEAK_W      = 8;
  localparam int TALLY_W     = 25;
  localparam int SQ_W        = 2 * PIXEL_BITS;
  localparam int ADD_W       = SQ_W + 2;
  localparam int IN_TDATA_W  = 6 * PIXEL_BITS;
  localparam int OUT_FIELD_W = ACC_W + PEAK_W + TALLY_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DIM_CFG_W;

  // Reset value of the frame width and height registers
  localparam logic [DIM_CFG_W-1:0] FRAME_DIM_RESET = DIM_CFG_W'(512);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BORDER_WIDTH = 2'd2,
    REG_COLOR_MODE   = 2'd3
  } cfg_reg_t;

  // One pixel pair, all three channels
  typedef struct packed {
    logic [PIXEL_BITS-1:0] orig_red;
    logic [PIXEL_BITS-1:0] filt_red;
    logic [PIXEL_BITS-1:0] orig_green;
    logic [PIXEL_BITS-1:0] filt_green;
    logic [PIXEL_BITS-1:0] orig_blue;
    logic [PIXEL_BITS-1:0] filt_blue;
  } pixel_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic   in_win;      // pixel lies inside the border window
    logic   frame_last;  // last pixel of the frame
    logic   color;       // color mode in force at accept
    pixel_t pix;
  } q_entry_t;

  // Squared absolute difference of two pixel values
  function automatic logic [SQ_W-1:0] sq_diff(input logic [PIXEL_BITS-1:0] a,
                                               input logic [PIXEL_BITS-1:0] b);
    logic [PIXEL_BITS-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

[src/psnr_error_accumulator_unit.sv]
// psnr_error_accumulator_unit: top level of the PSNR error accumulator.
// Uses psnr_pkg, psnr_front, psnr_queue and psnr_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | pixel pair, 6 x 8 bits
//  out_    | out | out_tvalid/out_tready| sum 42b, peak 8b, count 25b
//  cfg_    | in  | cfg_wr_en            | cfg_index selects, cfg_wdata 13b
//
// One item per cycle sustained, set by the square and accumulate path, unless
// a stalled result holds back a frame's last pixel; the result is registered.
// rst_n is synchronous: counters, sums and registers return to defaults.
// A stalled output holds only a new frame result; other pixels keep flowing
// through the two-entry queue until it fills.
module psnr_error_accumulator_unit #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // fields low to high: orig_red, filt_red, orig_green, filt_green,
  // orig_blue, filt_blue
  input  logic [psnr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // fields low to high: squared_error_sum, peak_value, treated_count, zeros
  output logic [psnr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [psnr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psnr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PB = psnr_pkg::PIXEL_BITS;

  psnr_pkg::pixel_t                 pix;
  psnr_pkg::q_entry_t               f_entry, q_head;
  logic                             accept, q_full, q_not_empty, q_pop;
  logic [psnr_pkg::OUT_FIELD_W-1:0] res_data;

  // Unpack input fields
  always_comb begin
    pix.orig_red   = in_tdata[0*PB +: PB];
    pix.filt_red   = in_tdata[1*PB +: PB];
    pix.orig_green = in_tdata[2*PB +: PB];
    pix.filt_green = in_tdata[3*PB +: PB];
    pix.orig_blue  = in_tdata[4*PB +: PB];
    pix.filt_blue  = in_tdata[5*PB +: PB];
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign out_tdata = psnr_pkg::OUT_TDATA_W'(res_data);

  psnr_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pix       (pix),
    .entry     (f_entry)
  );

  psnr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_entry (f_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  psnr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (res_data)
  );

endmodule

[src/psnr_front.sv]
// psnr_front: configuration registers, raster counters and window
// classification of incoming pixel pairs. Depends on psnr_pkg.
module psnr_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psnr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psnr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              accept,
  input  psnr_pkg::pixel_t                  pix,
  output psnr_pkg::q_entry_t                entry
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int DW = $clog2(MAX_DIMENSION + 1);

  logic [psnr_pkg::DIM_CFG_W-1:0] frame_width_r, frame_height_r;
  logic [psnr_pkg::BORDER_W-1:0]  border_width_r;
  logic                           color_mode_r;
  logic [CW-1:0]                  col_r, col_nxt, row_r, row_nxt;
  logic [DW-1:0]                  w_dim, h_dim;
  logic                           last_col, last_row, col_win, row_win;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= psnr_pkg::FRAME_DIM_RESET;
      frame_height_r <= psnr_pkg::FRAME_DIM_RESET;
      border_width_r <= '0;
      color_mode_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (psnr_pkg::cfg_reg_t'(cfg_index))
        psnr_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        psnr_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        psnr_pkg::REG_BORDER_WIDTH: border_width_r <= cfg_wdata[psnr_pkg::BORDER_W-1:0];
        psnr_pkg::REG_COLOR_MODE:   color_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, oversize clamps
  always_comb begin
    if (frame_width_r == '0)
      w_dim = DW'(1);
    else if (32'(frame_width_r) > 32'(MAX_DIMENSION))
      w_dim = DW'(MAX_DIMENSION);
    else
      w_dim = DW'(frame_width_r);
    if (frame_height_r == '0)
      h_dim = DW'(1);
    else if (32'(frame_height_r) > 32'(MAX_DIMENSION))
      h_dim = DW'(MAX_DIMENSION);
    else
      h_dim = DW'(frame_height_r);
  end

  // Window test and end-of-row / end-of-frame flags
  always_comb begin
    last_col = (32'(col_r) + 32'd1) >= 32'(w_dim);
    last_row = (32'(row_r) + 32'd1) >= 32'(h_dim);
    col_win  = (2 * 32'(border_width_r) < 32'(w_dim)) &&
               (32'(col_r) >= 32'(border_width_r)) &&
               (32'(col_r) + 32'(border_width_r) < 32'(w_dim));
    row_win  = (2 * 32'(border_width_r) < 32'(h_dim)) &&
               (32'(row_r) >= 32'(border_width_r)) &&
               (32'(row_r) + 32'(border_width_r) < 32'(h_dim));
  end

  // Counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (!last_col) begin
        col_nxt = col_r + CW'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Classified item
  always_comb begin
    entry.in_win     = col_win && row_win;
    entry.frame_last = last_col && last_row;
    entry.color      = color_mode_r;
    entry.pix        = pix;
  end

endmodule

[src/psnr_queue.sv]
// psnr_queue: two-entry queue between the front classifier and the back
// accumulator. Depends on psnr_pkg.
module psnr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psnr_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output psnr_pkg::q_entry_t head
);

  psnr_pkg::q_entry_t mem [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

[src/psnr_back.sv]
// psnr_back: squared-error stage, saturating accumulator, peak and tally,
// and the result register. Depends on psnr_pkg.
module psnr_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_not_empty,
  input  psnr_pkg::q_entry_t                   q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [psnr_pkg::OUT_FIELD_W-1:0]     out_data
);

  // Stage A: squared differences
  logic                            a_valid_r, a_win_r, a_last_r, a_color_r;
  logic [psnr_pkg::ADD_W-1:0]      a_add_r, a_add_nxt;
  logic [psnr_pkg::PIXEL_BITS-1:0] a_orig_r;
  logic                            a_ready, b_fire;

  // Stage B: accumulation state and result register
  logic [psnr_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [psnr_pkg::ACC_W:0]         acc_sum;
  logic [psnr_pkg::PEAK_W-1:0]      peak_r, peak_nxt, peak_out;
  logic [psnr_pkg::TALLY_W-1:0]     tally_r, tally_nxt;
  logic                             out_valid_r;
  logic [psnr_pkg::OUT_FIELD_W-1:0] out_data_r;

  // A last item waits only while an unread result still sits in the register
  assign b_fire    = a_valid_r && !(a_last_r && out_valid_r && !out_ready);
  assign a_ready   = !a_valid_r || b_fire;
  assign q_pop     = a_ready && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    a_add_nxt = psnr_pkg::ADD_W'(psnr_pkg::sq_diff(q_head.pix.orig_red, q_head.pix.filt_red));
    if (q_head.color)
      a_add_nxt = a_add_nxt
        + psnr_pkg::ADD_W'(psnr_pkg::sq_diff(q_head.pix.orig_green, q_head.pix.filt_green))
        + psnr_pkg::ADD_W'(psnr_pkg::sq_diff(q_head.pix.orig_blue, q_head.pix.filt_blue));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_add_r   <= a_add_nxt;
      a_win_r   <= q_head.in_win;
      a_last_r  <= q_head.frame_last;
      a_color_r <= q_head.color;
      a_orig_r  <= q_head.pix.orig_red;
    end
  end

  // Updated sums for the item in stage A
  always_comb begin
    acc_sum   = {1'b0, acc_r} + (psnr_pkg::ACC_W + 1)'(a_add_r);
    acc_nxt   = acc_r;
    peak_nxt  = peak_r;
    tally_nxt = tally_r;
    if (a_win_r) begin
      acc_nxt = acc_sum[psnr_pkg::ACC_W] ? '1 : acc_sum[psnr_pkg::ACC_W-1:0];
      if (!a_color_r && (a_orig_r > peak_r)) peak_nxt = a_orig_r;
      if (tally_r != '1) tally_nxt = tally_r + psnr_pkg::TALLY_W'(1);
    end
    peak_out = a_color_r ? '1 : peak_nxt;
  end

  // Accumulate, or hand over the frame result and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      peak_r      <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_fire) begin
        if (a_last_r) begin
          acc_r   <= '0;
          peak_r  <= '0;
          tally_r <= '0;
        end else begin
          acc_r   <= acc_nxt;
          peak_r  <= peak_nxt;
          tally_r <= tally_nxt;
        end
      end
      if (b_fire && a_last_r) out_valid_r <= 1'b1;
      else if (out_ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && a_last_r) out_data_r <= {tally_nxt, peak_out, acc_nxt};
  end

endmodule

[src/psnr_checker.sv]
// psnr_checker: port-level checks on the result channel of the PSNR error
// accumulator, bound to the top level. Depends on psnr_pkg.
module psnr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [psnr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // An empty window gives a zero sum
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[74:50] == 25'd0) |-> (out_tdata[41:0] == 42'd0))
    else $error("nonzero sum with no treated pixel");

  // An empty window gives peak zero (grey) or full scale (color)
  a_empty_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[74:50] == 25'd0) |->
      (out_tdata[49:42] == 8'd0) || (out_tdata[49:42] == 8'd255))
    else $error("peak set with no treated pixel");

  // Padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[79:75] == 5'd0))
    else $error("padding bits set");

  // A result sum never exceeds 3 * 255^2 per treated pixel
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({22'd0, out_tdata[41:0]} <= 64'(out_tdata[74:50]) * 64'd195075))
    else $error("sum above bound for treated count");

endmodule

bind psnr_error_accumulator_unit psnr_checker u_psnr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
